>>> hdl/rorc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rorc_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 24;
  localparam int RMS_W    = 23;
  localparam int THR_W    = 23;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = 55;
  // Square-root width: half the sum width, rounded up
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int LOOP_W   = $clog2(ROOT_W + 1);
  localparam int CFG_IDX_W = 8;

  localparam int WINDOW_SAMPLES_DEF = 80;

  localparam logic [THR_W-1:0] PICKUP_RESET = THR_W'(20480);
  localparam logic [THR_W-1:0] BF_RESET     = THR_W'(294400);
  localparam logic [RMS_W-1:0] RMS_MAX      = {RMS_W{1'b1}};

  localparam logic [LOOP_W-1:0] SQRT_STEPS = LOOP_W'(ROOT_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PICKUP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BF     = CFG_IDX_W'(1);

  // Step counter
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_SQUARE    = 4'd1;
  localparam op_t OP_ADD       = 4'd2;
  localparam op_t OP_LOAD_SQRT = 4'd5;
  localparam op_t OP_SQRT      = 4'd6;
  localparam op_t OP_STORE     = 4'd7;
  localparam op_t OP_CLEAR     = 4'd8;
  localparam op_t OP_EMIT_RMS  = 4'd9;
  localparam op_t OP_EMIT_CHK  = 4'd10;

  // Jump conditions
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEXT       = 4'd0;
  localparam cond_t C_ALWAYS     = 4'd1;
  localparam cond_t C_NO_ACCEPT  = 4'd2;
  localparam cond_t C_IS_CHECK   = 4'd3;
  localparam cond_t C_NO_MATCH   = 4'd4;
  localparam cond_t C_WIN_OPEN   = 4'd5;
  localparam cond_t C_LOOP_MORE  = 4'd6;
  localparam cond_t C_PHASE_MORE = 4'd7;
  localparam cond_t C_OUT_BUSY   = 4'd8;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic is_check;
    logic match;
    logic win_open;
    logic loop_more;
    logic phase_more;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/three_phase_rms_overcurrent_relay_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-phase windowed RMS overcurrent relay. Matched sample beats add the
// squares of the three signed Q15.8 phase currents to 55-bit sums; after
// WINDOW_SAMPLES matched beats one RMS result (unsigned Q15.8, saturated) is
// sent and the window restarts. A check beat compares the held phase A RMS
// with the pickup and breaker-fail thresholds and sends one decision result.
// A small microprogram steps a shared datapath. The beat that closes a window
// runs, per phase, a bit-per-cycle square root whose trial terms carry the
// window length, so no divide is needed, plus one step each of load and
// store. A waiting result sits in the output register while the next beat is
// taken; the block stalls only when a second result is ready before the first
// was taken. Config writes are always ready.

module three_phase_rms_overcurrent_relay_core #(
  parameter int WINDOW_SAMPLES = rorc_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rorc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rorc_pkg::THR_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 func,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_a,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_b,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_c,
  input  wire logic                                 stream_match,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      is_check_result,
  output logic [rorc_pkg::RMS_W-1:0]                rms_a,
  output logic [rorc_pkg::RMS_W-1:0]                rms_b,
  output logic [rorc_pkg::RMS_W-1:0]                rms_c,
  output logic                                      overcurrent_trip,
  output logic                                      breaker_fail
);

  logic [rorc_pkg::THR_W-1:0] pickup_threshold;
  logic [rorc_pkg::THR_W-1:0] breaker_fail_threshold;
  rorc_pkg::ctrl_t            ctrl;
  rorc_pkg::status_t          status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pickup_threshold       <= rorc_pkg::PICKUP_RESET;
      breaker_fail_threshold <= rorc_pkg::BF_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == rorc_pkg::REG_PICKUP) begin
        pickup_threshold <= cfg_data;
      end else if (cfg_index == rorc_pkg::REG_BF) begin
        breaker_fail_threshold <= cfg_data;
      end
    end
  end

  assign in_ready = ctrl.accept;

  rorc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  rorc_dp #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .ctrl                   (ctrl),
    .in_accept              (in_valid && in_ready),
    .func                   (func),
    .sample_a               (sample_a),
    .sample_b               (sample_b),
    .sample_c               (sample_c),
    .stream_match           (stream_match),
    .pickup_threshold       (pickup_threshold),
    .breaker_fail_threshold (breaker_fail_threshold),
    .status                 (status),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .is_check_result        (is_check_result),
    .rms_a                  (rms_a),
    .rms_b                  (rms_b),
    .rms_c                  (rms_c),
    .overcurrent_trip       (overcurrent_trip),
    .breaker_fail           (breaker_fail)
  );

endmodule

`default_nettype wire

>>> hdl/rorc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rorc_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire rorc_pkg::status_t status,
  output rorc_pkg::ctrl_t        ctrl
);

  rorc_pkg::step_t step;
  rorc_pkg::step_t step_next;
  logic            take;

  // Microprogram
  always_comb begin
    unique case (step)
      4'd0:  ctrl = '{1'b1, rorc_pkg::OP_NOP,       rorc_pkg::C_NO_ACCEPT,  4'd0};
      4'd1:  ctrl = '{1'b0, rorc_pkg::OP_NOP,       rorc_pkg::C_IS_CHECK,   4'd12};
      4'd2:  ctrl = '{1'b0, rorc_pkg::OP_NOP,       rorc_pkg::C_NO_MATCH,   4'd0};
      4'd3:  ctrl = '{1'b0, rorc_pkg::OP_SQUARE,    rorc_pkg::C_NEXT,       4'd0};
      4'd4:  ctrl = '{1'b0, rorc_pkg::OP_ADD,       rorc_pkg::C_NEXT,       4'd0};
      4'd5:  ctrl = '{1'b0, rorc_pkg::OP_NOP,       rorc_pkg::C_WIN_OPEN,   4'd0};
      4'd6:  ctrl = '{1'b0, rorc_pkg::OP_LOAD_SQRT, rorc_pkg::C_NEXT,       4'd0};
      4'd7:  ctrl = '{1'b0, rorc_pkg::OP_SQRT,      rorc_pkg::C_LOOP_MORE,  4'd7};
      4'd8:  ctrl = '{1'b0, rorc_pkg::OP_STORE,     rorc_pkg::C_PHASE_MORE, 4'd6};
      4'd9:  ctrl = '{1'b0, rorc_pkg::OP_CLEAR,     rorc_pkg::C_NEXT,       4'd0};
      4'd10: ctrl = '{1'b0, rorc_pkg::OP_EMIT_RMS,  rorc_pkg::C_OUT_BUSY,   4'd10};
      4'd11: ctrl = '{1'b0, rorc_pkg::OP_NOP,       rorc_pkg::C_ALWAYS,     4'd0};
      4'd12: ctrl = '{1'b0, rorc_pkg::OP_EMIT_CHK,  rorc_pkg::C_OUT_BUSY,   4'd12};
      default: ctrl = '{1'b0, rorc_pkg::OP_NOP,     rorc_pkg::C_ALWAYS,     4'd0};
    endcase
  end

  // Jump condition select
  always_comb begin
    unique case (ctrl.cond)
      rorc_pkg::C_NEXT:       take = 1'b0;
      rorc_pkg::C_ALWAYS:     take = 1'b1;
      rorc_pkg::C_NO_ACCEPT:  take = !in_valid;
      rorc_pkg::C_IS_CHECK:   take = status.is_check;
      rorc_pkg::C_NO_MATCH:   take = !status.match;
      rorc_pkg::C_WIN_OPEN:   take = status.win_open;
      rorc_pkg::C_LOOP_MORE:  take = status.loop_more;
      rorc_pkg::C_PHASE_MORE: take = status.phase_more;
      rorc_pkg::C_OUT_BUSY:   take = status.out_busy;
      default:                take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rorc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rorc_dp #(
  parameter int WINDOW_SAMPLES = rorc_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rorc_pkg::ctrl_t               ctrl,
  input  wire logic                          in_accept,
  input  wire logic                          func,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_a,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_b,
  input  wire logic signed [rorc_pkg::SAMPLE_W-1:0] sample_c,
  input  wire logic                          stream_match,
  input  wire logic [rorc_pkg::THR_W-1:0]    pickup_threshold,
  input  wire logic [rorc_pkg::THR_W-1:0]    breaker_fail_threshold,
  output rorc_pkg::status_t                  status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               is_check_result,
  output logic [rorc_pkg::RMS_W-1:0]         rms_a,
  output logic [rorc_pkg::RMS_W-1:0]         rms_b,
  output logic [rorc_pkg::RMS_W-1:0]         rms_c,
  output logic                               overcurrent_trip,
  output logic                               breaker_fail
);

  localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
  // Trial terms: window length times squares of partial roots, with headroom
  localparam int ACC_W = CNT_W + 2 * rorc_pkg::ROOT_W - 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SAMPLES);
  localparam logic [ACC_W-1:0] Q_INIT   =
    ACC_W'(WINDOW_SAMPLES) << (2 * (rorc_pkg::ROOT_W - 1));

  localparam int SW = rorc_pkg::SAMPLE_W;
  localparam int RW = rorc_pkg::RMS_W;

  // Captured item
  logic          func_r;
  logic          match_r;
  logic [SW-1:0] samp [3];

  // Accumulators and held results
  logic [rorc_pkg::SQ_W-1:0]  sq [3];
  logic [rorc_pkg::SUM_W-1:0] sum_sq [3];
  logic [RW-1:0]              held [3];
  logic [CNT_W-1:0]           window_count;
  logic [1:0]                 phase;

  // Square-root unit; the root r is the largest with WINDOW_SAMPLES * r^2 <= sum,
  // which equals the root of the floored mean
  logic [rorc_pkg::SUM_W-1:0]  sq_rem;
  logic [ACC_W-1:0]            sq_p;
  logic [ACC_W-1:0]            sq_q;
  logic [rorc_pkg::ROOT_W-1:0] root;
  logic [rorc_pkg::LOOP_W-1:0] loop_cnt;

  logic [rorc_pkg::SUM_W-1:0]  sum_sel;
  logic [ACC_W-1:0]            sq_trial;
  logic [ACC_W-1:0]            sq_step;
  logic                        sq_ge;
  logic [RW-1:0]               root_sat;
  logic                        trip;
  logic                        out_busy;

  function automatic logic [rorc_pkg::SQ_W-1:0] square_mag(input logic [SW-1:0] s);
    logic [SW-1:0] mag;
    mag = s[SW-1] ? (~s + SW'(1)) : s;
    return mag * mag;
  endfunction

  // Sum of the phase under conversion
  always_comb begin
    case (phase)
      2'd0:    sum_sel = sum_sq[0];
      2'd1:    sum_sel = sum_sq[1];
      default: sum_sel = sum_sq[2];
    endcase
  end

  // Square-root step, one root bit per cycle:
  // p = W * r * 2^(i+1), q = W * 4^i, trial growth of W * r^2 is p + q
  assign sq_trial = sq_p + sq_q;
  assign sq_step  = sq_p + {sq_q[ACC_W-2:0], 1'b0};
  assign sq_ge    = sq_trial <= ACC_W'(sq_rem);
  assign root_sat = (root > rorc_pkg::ROOT_W'(rorc_pkg::RMS_MAX)) ? rorc_pkg::RMS_MAX
                                                                  : root[RW-1:0];

  assign trip     = held[0] > pickup_threshold;
  assign out_busy = out_valid && !out_ready;

  assign status.is_check   = func_r;
  assign status.match      = match_r;
  assign status.win_open   = window_count != CNT_FULL;
  assign status.loop_more  = loop_cnt != rorc_pkg::LOOP_W'(1);
  assign status.phase_more = phase != 2'd2;
  assign status.out_busy   = out_busy;

  // Input capture and squaring
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= func;
      match_r <= stream_match;
      samp[0] <= sample_a;
      samp[1] <= sample_b;
      samp[2] <= sample_c;
    end
    if (ctrl.op == rorc_pkg::OP_SQUARE) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= square_mag(samp[i]);
      end
    end
  end

  // Window accumulators, phase pointer and held RMS values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum_sq[i] <= '0;
        held[i]   <= '0;
      end
      window_count <= '0;
      phase        <= '0;
    end else begin
      case (ctrl.op)
        rorc_pkg::OP_ADD: begin
          for (int i = 0; i < 3; i++) begin
            sum_sq[i] <= sum_sq[i] + rorc_pkg::SUM_W'(sq[i]);
          end
          window_count <= window_count + CNT_W'(1);
        end
        rorc_pkg::OP_STORE: begin
          held[phase] <= root_sat;
          phase       <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        end
        rorc_pkg::OP_CLEAR: begin
          for (int i = 0; i < 3; i++) begin
            sum_sq[i] <= '0;
          end
          window_count <= '0;
          phase        <= '0;
        end
        default: ;
      endcase
    end
  end

  // Square-root iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_cnt <= '0;
    end else begin
      case (ctrl.op)
        rorc_pkg::OP_LOAD_SQRT: begin
          sq_rem   <= sum_sel;
          sq_p     <= '0;
          sq_q     <= Q_INIT;
          root     <= '0;
          loop_cnt <= rorc_pkg::SQRT_STEPS;
        end
        rorc_pkg::OP_SQRT: begin
          sq_rem   <= sq_ge ? (sq_rem - sq_trial[rorc_pkg::SUM_W-1:0]) : sq_rem;
          sq_p     <= (sq_ge ? sq_step : sq_p) >> 1;
          sq_q     <= sq_q >> 2;
          root     <= {root[rorc_pkg::ROOT_W-2:0], sq_ge};
          loop_cnt <= loop_cnt - rorc_pkg::LOOP_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_busy && (ctrl.op == rorc_pkg::OP_EMIT_RMS ||
                               ctrl.op == rorc_pkg::OP_EMIT_CHK)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_busy && (ctrl.op == rorc_pkg::OP_EMIT_RMS ||
                      ctrl.op == rorc_pkg::OP_EMIT_CHK)) begin
      is_check_result  <= ctrl.op == rorc_pkg::OP_EMIT_CHK;
      rms_a            <= held[0];
      rms_b            <= held[1];
      rms_c            <= held[2];
      overcurrent_trip <= (ctrl.op == rorc_pkg::OP_EMIT_CHK) && trip;
      breaker_fail     <= (ctrl.op == rorc_pkg::OP_EMIT_CHK) && trip &&
                          (held[0] >= breaker_fail_threshold);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_FULL)
    else $error("window count past window length");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({is_check_result, rms_a, rms_b, rms_c, overcurrent_trip, breaker_fail}))
    else $error("result beat changed while waiting");

  a_bf_needs_trip: assert property (@(posedge clk) disable iff (rst)
    out_valid && breaker_fail |-> overcurrent_trip)
    else $error("breaker fail without trip");

  a_rms_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_check_result |-> !overcurrent_trip && !breaker_fail)
    else $error("flags set on window result");

endmodule

`default_nettype wire

>>> tb/sv/rorc_rms_trip_checker.sv
`timescale 1ns / 1ps

// Watches the config, sample and result channels of the relay core, keeps its
// own copy of the window sums, held RMS values and thresholds, and compares
// every result beat with the oldest predicted one.
module rorc_rms_trip_checker #(
  parameter int WINDOW_LEN = rorc_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rorc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rorc_pkg::THR_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 func,
  input  logic signed [rorc_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [rorc_pkg::SAMPLE_W-1:0] sample_b,
  input  logic signed [rorc_pkg::SAMPLE_W-1:0] sample_c,
  input  logic                                 stream_match,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 is_check_result,
  input  logic [rorc_pkg::RMS_W-1:0]           rms_a,
  input  logic [rorc_pkg::RMS_W-1:0]           rms_b,
  input  logic [rorc_pkg::RMS_W-1:0]           rms_c,
  input  logic                                 overcurrent_trip,
  input  logic                                 breaker_fail,
  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   windows_seen,
  output int                                   decisions_seen
);
  import rorc_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef logic [RMS_W-1:0] rms_t;

  typedef struct packed {
    logic is_check;
    rms_t a;
    rms_t b;
    rms_t c;
    logic trip;
    logic bf;
  } relay_out_t;

  // Predicted block state
  logic [SUM_W-1:0] sq_sum_a, sq_sum_b, sq_sum_c;
  int               fill;
  rms_t             hold_a, hold_b, hold_c;
  logic [THR_W-1:0] pickup_thr, bf_thr;

  relay_out_t relay_expect_q[$];
  int         fails;
  int         n_win;
  int         n_dec;

  // Exact square of a signed Q15.8 sample; full-scale negative gives 2^46
  function automatic logic [SUM_W-1:0] phase_square(logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W:0] mag;
    mag = s[SAMPLE_W-1] ? (((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, s}) : {1'b0, s};
    return SUM_W'(mag) * SUM_W'(mag);
  endfunction

  // floor(sqrt(floor(sum / window))), saturated to the RMS width
  function automatic rms_t window_rms_of(logic [SUM_W-1:0] sum);
    logic [63:0] mean;
    logic [63:0] trial;
    logic [63:0] root;
    mean = 64'(sum) / 64'(WINDOW_LEN);
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= mean) root = trial;
    end
    return (root > 64'(RMS_MAX)) ? RMS_MAX : rms_t'(root);
  endfunction

  always @(posedge clk) begin
    relay_out_t want;
    relay_out_t got;
    logic       trip_now;
    if (rst) begin
      sq_sum_a = '0;
      sq_sum_b = '0;
      sq_sum_c = '0;
      fill = 0;
      hold_a = '0;
      hold_b = '0;
      hold_c = '0;
      pickup_thr = PICKUP_RESET;
      bf_thr = BF_RESET;
      relay_expect_q.delete();
      fails = 0;
      n_win = 0;
      n_dec = 0;
    end else begin
      // Register writes; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PICKUP) pickup_thr = cfg_data;
        else if (cfg_index == REG_BF) bf_thr = cfg_data;
      end

      // Result beat against the oldest prediction
      if (out_valid && out_ready) begin
        got = {is_check_result, rms_a, rms_b, rms_c, overcurrent_trip, breaker_fail};
        if (relay_expect_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: kind=%0d rms=%0d/%0d/%0d trip=%0d bf=%0d",
                     $realtime, got.is_check, got.a, got.b, got.c, got.trip, got.bf);
        end else begin
          want = relay_expect_q.pop_front();
          if (got != want) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: mismatch, expected kind=%0d rms=%0d/%0d/%0d trip=%0d bf=%0d",
                       $realtime, want.is_check, want.a, want.b, want.c, want.trip, want.bf);
              $display("%0t:                got kind=%0d rms=%0d/%0d/%0d trip=%0d bf=%0d",
                       $realtime, got.is_check, got.a, got.b, got.c, got.trip, got.bf);
            end
          end
          if (want.is_check) n_dec++;
          else n_win++;
        end
      end

      // Input beat: func set means protection check, else a sample set
      if (in_valid && in_ready) begin
        if (func) begin
          trip_now = hold_a > pickup_thr;
          relay_expect_q.push_back(relay_out_t'({1'b1, hold_a, hold_b, hold_c, trip_now,
                                                 trip_now && (hold_a >= bf_thr)}));
        end else if (stream_match) begin
          sq_sum_a = sq_sum_a + phase_square(sample_a);
          sq_sum_b = sq_sum_b + phase_square(sample_b);
          sq_sum_c = sq_sum_c + phase_square(sample_c);
          fill++;
          // Window full: hold the RMS values and restart
          if (fill >= WINDOW_LEN) begin
            hold_a = window_rms_of(sq_sum_a);
            hold_b = window_rms_of(sq_sum_b);
            hold_c = window_rms_of(sq_sum_c);
            sq_sum_a = '0;
            sq_sum_b = '0;
            sq_sum_c = '0;
            fill = 0;
            relay_expect_q.push_back(relay_out_t'({1'b0, hold_a, hold_b, hold_c,
                                                   1'b0, 1'b0}));
          end
        end
      end
    end

    fail_count <= fails;
    pending_count <= relay_expect_q.size();
    windows_seen <= n_win;
    decisions_seen <= n_dec;
  end

endmodule

>>> tb/sv/tb_three_phase_rms_overcurrent_relay_core.sv
`timescale 1ns / 1ps

module tb_three_phase_rms_overcurrent_relay_core;
  import rorc_pkg::*;

  localparam int RANDOM_ITEMS    = 1250;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int CHECK_PCT       = 12;
  localparam int UNMATCHED_PCT   = 10;
  localparam int NEAR_THR_SPREAD = 200000;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = {CFG_IDX_W{1'b1}};

  localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // Amplitude shape used for the random matched samples of one window
  typedef enum int {
    PROF_FULL,
    PROF_NEAR_THR,
    PROF_SMALL,
    PROF_EXTREME,
    PROF_NEG_FULL
  } window_profile_e;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [THR_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       func;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic signed [SAMPLE_W-1:0] sample_c;
  logic                       stream_match;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       is_check_result;
  logic [RMS_W-1:0]           rms_a;
  logic [RMS_W-1:0]           rms_b;
  logic [RMS_W-1:0]           rms_c;
  logic                       overcurrent_trip;
  logic                       breaker_fail;

  int fail_count;
  int pending_count;
  int windows_seen;
  int decisions_seen;

  int              send_gap_pct = 0;
  int              recv_stall_pct = 0;
  logic [THR_W-1:0] pickup_now;
  logic [THR_W-1:0] bf_now;
  window_profile_e profile;
  int              near_target;
  int              fill_sent;
  int              sent_items;
  int              sent_matched;
  int              sent_checks;
  int              cycle_count = 0;

  three_phase_rms_overcurrent_relay_core DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .sample_a         (sample_a),
    .sample_b         (sample_b),
    .sample_c         (sample_c),
    .stream_match     (stream_match),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_check_result  (is_check_result),
    .rms_a            (rms_a),
    .rms_b            (rms_b),
    .rms_c            (rms_c),
    .overcurrent_trip (overcurrent_trip),
    .breaker_fail     (breaker_fail)
  );

  rorc_rms_trip_checker u_relay_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .sample_a         (sample_a),
    .sample_b         (sample_b),
    .sample_c         (sample_c),
    .stream_match     (stream_match),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_check_result  (is_check_result),
    .rms_a            (rms_a),
    .rms_b            (rms_b),
    .rms_c            (rms_c),
    .overcurrent_trip (overcurrent_trip),
    .breaker_fail     (breaker_fail),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .windows_seen     (windows_seen),
    .decisions_seen   (decisions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[three_phase_rms_overcurrent_relay_core] ERROR");
      $finish;
    end
  end

  // New window shape; near-threshold windows aim phase A RMS at a threshold +-1
  task automatic pick_profile();
    int base;
    profile = window_profile_e'($urandom_range(0, 4));
    base = $urandom_range(0, 1) ? int'(pickup_now) : int'(bf_now);
    near_target = base + int'($urandom_range(0, 2)) - 1;
    if (near_target < 0) near_target = 0;
    if (near_target > int'(THR_MAX)) near_target = int'(THR_MAX);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // One phase sample under the current profile; lead is phase A
  function automatic logic signed [SAMPLE_W-1:0] shaped_sample(logic lead);
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom());
    case (profile)
      PROF_NEAR_THR: begin
        if (!lead) return raw;
        return $urandom_range(0, 1) ? -SAMPLE_W'(near_target) : SAMPLE_W'(near_target);
      end
      PROF_SMALL:    return raw >>> $urandom_range(0, SAMPLE_W - 1);
      PROF_EXTREME:  return extreme_sample();
      PROF_NEG_FULL: return lead ? SAMPLE_MIN : extreme_sample();
      default:       return raw;
    endcase
  endfunction

  // Present one input beat, with random gaps ahead of it, and wait for accept
  task automatic send_item(input logic f, input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b,
                           input logic signed [SAMPLE_W-1:0] c, input logic m);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    stream_match <= m;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (f == FUNC_CHECK) begin
      sent_checks++;
    end else if (m) begin
      sent_matched++;
      fill_sent++;
      if (fill_sent == WINDOW_SAMPLES_DEF) begin
        fill_sent = 0;
        pick_profile();
      end
    end
  endtask

  task automatic send_random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < CHECK_PCT)
      send_item(FUNC_CHECK, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)));
    else if (roll < CHECK_PCT + UNMATCHED_PCT)
      send_item(FUNC_SAMPLE, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                SAMPLE_W'($urandom()), 1'b0);
    else
      send_item(FUNC_SAMPLE, shaped_sample(1'b1), shaped_sample(1'b0),
                shaped_sample(1'b0), 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PICKUP) pickup_now = val;
    else if (idx == REG_BF) bf_now = val;
  endtask

  // Drop valid, wait for every predicted result, then let the datapath settle
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [THR_W-1:0] thr;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_SAMPLE;
    sample_a = '0;
    sample_b = '0;
    sample_c = '0;
    stream_match = 1'b0;
    pickup_now = PICKUP_RESET;
    bf_now = BF_RESET;
    fill_sent = 0;
    sent_items = 0;
    sent_matched = 0;
    sent_checks = 0;
    pick_profile();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Writes to unused indexes must leave the thresholds at reset
    write_reg(REG_SPARE, THR_MAX);
    write_reg(REG_LAST, '0);

    // Directed: check before any window, unmatched beats, extreme samples
    send_item(FUNC_CHECK, '0, '0, '0, 1'b1);
    send_item(FUNC_CHECK, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_item(FUNC_SAMPLE, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_item(FUNC_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, '1, 1'b0);
    send_item(FUNC_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    send_item(FUNC_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_item(FUNC_SAMPLE, '0, '0, '0, 1'b1);
    send_item(FUNC_SAMPLE, '1, SAMPLE_W'(1), '1, 1'b1);
    send_item(FUNC_SAMPLE, SAMPLE_MAX, '0, SAMPLE_MIN, 1'b1);
    send_item(FUNC_CHECK, SAMPLE_MAX, '1, '0, 1'b1);

    // Random phases: handshake pressure and thresholds change between them
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_quiet();
        send_gap_pct = (ph == 1) ? 53 : (ph == 3) ? 37 : 0;
        recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 37 : 0;
        case (ph)
          1: begin
            write_reg(REG_PICKUP, '0);
            write_reg(REG_BF, THR_MAX);
          end
          2: begin
            write_reg(REG_PICKUP, THR_MAX);
            write_reg(REG_BF, '0);
          end
          default: begin
            thr = THR_W'($urandom_range(0, 400000));
            write_reg(REG_PICKUP, thr);
            write_reg(REG_BF, thr + THR_W'($urandom_range(0, NEAR_THR_SPREAD)));
          end
        endcase
      end
      repeat (RANDOM_ITEMS / 4) send_random_item();
    end
    wait_quiet();

    $display("covered %0d beats (%0d matched samples, %0d checks) in four pressure phases",
             sent_items, sent_matched, sent_checks);
    $display("%0d windows and %0d trip decisions compared; thresholds reset, extreme, random",
             windows_seen, decisions_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[three_phase_rms_overcurrent_relay_core] OK");
    end else begin
      $display("[three_phase_rms_overcurrent_relay_core] ERROR");
    end
    $finish;
  end

endmodule
